/* rtl/wsdf_pkg.sv */
// ----------------------------------------------------------------------------
// WebSocket frame deframer package
// Parse phases, result kinds, opcodes and header codes for the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package wsdf_pkg;

    // Parse phase, one-hot.
    typedef enum logic [4:0] {
        PH_HDR0 = 5'b00001,
        PH_HDR1 = 5'b00010,
        PH_EXT  = 5'b00100,
        PH_KEY  = 5'b01000,
        PH_DATA = 5'b10000
    } t_phase;

    // Result kinds.
    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_PONG    = 2'd1;
    localparam logic [1:0] KIND_CLOSE   = 2'd2;
    localparam logic [1:0] KIND_ABANDON = 2'd3;

    // Opcodes.
    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    // Seven-bit length codes that announce an extended length.
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Extension or key bytes still due, minus one.
    localparam logic [2:0] CNT_EXT16 = 3'd1;
    localparam logic [2:0] CNT_EXT64 = 3'd7;
    localparam logic [2:0] CNT_KEY   = 3'd3;

    // Command codes.
    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_RESET = 1'b1;

    localparam logic [31:0] OFFSET_MAX = 32'hFFFF_FFFF;

endpackage : wsdf_pkg

`default_nettype wire

/* rtl/websocket_frame_deframer.sv */
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Receive-side frame parser: header, extended length, mask key, unmasking and
// message reassembly, one stream byte per clock while no result is stalled.
// ----------------------------------------------------------------------------
// The deframer accepts one received byte (or a new-connection command) per
// clock unless the result register stalls, and gives at most one result per
// byte, which passes through the input register and then the result register.
// The rate is one transaction per clock; the longest path is the 64-bit
// decrement and compare of the remaining payload length together with
// the per-byte parse decision. A result waiting in the output register holds
// the parser: the input register and the result register advance together
// only while the result register is empty or is being taken, so during such
// a stall one further byte can wait in the input register and no more.
// Bytes that produce no result (header, length and key bytes, close and pong
// payload) pass through the parser under the same condition and update its
// state.
`default_nettype none

module websocket_frame_deframer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input channel.
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_command,
    input  wire logic [7:0]  i_rx_byte,
    // Result channel.
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_kind,
    output logic             o_has_byte,
    output logic [7:0]       o_data_byte,
    output logic [3:0]       o_msg_opcode,
    output logic [31:0]      o_offset,
    output logic             o_last
);

    import wsdf_pkg::*;

    // ------------------------------------------------------------------
    // Input register. It is taken whenever it is empty or its transaction
    // is being processed in this cycle.
    // ------------------------------------------------------------------
    logic       r_in_valid;
    logic       r_in_command;
    logic [7:0] r_in_byte;

    logic       advance;   // result register can take a new value
    logic       fire;      // the held transaction is processed this cycle

    assign advance = !o_valid || i_ready;
    assign fire    = r_in_valid && advance;
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_command <= i_command;
            r_in_byte    <= i_rx_byte;
        end
    end

    // ------------------------------------------------------------------
    // Parse state.
    // ------------------------------------------------------------------
    t_phase      r_phase,        n_phase;
    logic        r_frame_fin,    n_frame_fin;
    logic [3:0]  r_frame_opcode, n_frame_opcode;
    logic        r_frame_masked, n_frame_masked;
    logic [63:0] r_remaining,    n_remaining;
    logic [2:0]  r_hdr_count,    n_hdr_count;
    logic [31:0] r_mask_key,     n_mask_key;
    logic [1:0]  r_mask_index,   n_mask_index;
    logic [3:0]  r_msg_opcode,   n_msg_opcode;
    logic        r_msg_open,     n_msg_open;
    logic [31:0] r_msg_offset,   n_msg_offset;
    logic [31:0] r_ping_offset,  n_ping_offset;

    // Result of the current transaction.
    logic        res_valid;
    logic [1:0]  res_kind;
    logic        res_has_byte;
    logic [7:0]  res_byte;
    logic [31:0] res_offset;
    logic        res_last;

    always_comb begin
        logic [3:0] op;
        logic [6:0] len7;
        logic [7:0] key_byte;
        logic [7:0] d;
        logic       frame_end;
        logic       do_after_len;
        logic       do_begin;

        n_phase        = r_phase;
        n_frame_fin    = r_frame_fin;
        n_frame_opcode = r_frame_opcode;
        n_frame_masked = r_frame_masked;
        n_remaining    = r_remaining;
        n_hdr_count    = r_hdr_count;
        n_mask_key     = r_mask_key;
        n_mask_index   = r_mask_index;
        n_msg_opcode   = r_msg_opcode;
        n_msg_open     = r_msg_open;
        n_msg_offset   = r_msg_offset;
        n_ping_offset  = r_ping_offset;

        res_valid    = 1'b0;
        res_kind     = KIND_DATA;
        res_has_byte = 1'b0;
        res_byte     = 8'd0;
        res_offset   = 32'd0;
        res_last     = 1'b0;

        op           = r_in_byte[3:0];
        len7         = r_in_byte[6:0];
        key_byte     = 8'd0;
        d            = r_in_byte;
        frame_end    = 1'b0;
        do_after_len = 1'b0;
        do_begin     = 1'b0;

        if (r_in_command == CMD_RESET) begin
            n_phase        = PH_HDR0;
            n_frame_fin    = 1'b0;
            n_frame_opcode = OP_CONT;
            n_frame_masked = 1'b0;
            n_remaining    = 64'd0;
            n_hdr_count    = 3'd0;
            n_mask_key     = 32'd0;
            n_mask_index   = 2'd0;
            n_msg_opcode   = OP_TEXT;
            n_msg_open     = 1'b0;
            n_msg_offset   = 32'd0;
            n_ping_offset  = 32'd0;
        end else begin
            case (r_phase)
                PH_HDR1: begin
                    n_frame_masked = r_in_byte[7];
                    n_remaining    = 64'd0;
                    if (len7 == LEN_EXT16) begin
                        n_phase     = PH_EXT;
                        n_hdr_count = CNT_EXT16;
                    end else if (len7 == LEN_EXT64) begin
                        n_phase     = PH_EXT;
                        n_hdr_count = CNT_EXT64;
                    end else begin
                        n_remaining  = {57'd0, len7};
                        do_after_len = 1'b1;
                    end
                end
                PH_EXT: begin
                    n_remaining = {r_remaining[55:0], r_in_byte};
                    if (r_hdr_count == 3'd0) begin
                        do_after_len = 1'b1;
                    end else begin
                        n_hdr_count = r_hdr_count - 3'd1;
                    end
                end
                PH_KEY: begin
                    n_mask_key = {r_mask_key[23:0], r_in_byte};
                    if (r_hdr_count == 3'd0) begin
                        do_begin = 1'b1;
                    end else begin
                        n_hdr_count = r_hdr_count - 3'd1;
                    end
                end
                PH_DATA: begin
                    case (r_mask_index)
                        2'd0:    key_byte = r_mask_key[31:24];
                        2'd1:    key_byte = r_mask_key[23:16];
                        2'd2:    key_byte = r_mask_key[15:8];
                        default: key_byte = r_mask_key[7:0];
                    endcase
                    if (r_frame_masked) begin
                        d = r_in_byte ^ key_byte;
                    end
                    n_mask_index = r_mask_index + 2'd1;
                    n_remaining  = r_remaining - 64'd1;
                    frame_end    = (r_remaining == 64'd1);
                    if (frame_end) begin
                        n_phase = PH_HDR0;
                    end
                    if (r_frame_opcode == OP_PING) begin
                        res_valid     = 1'b1;
                        res_kind      = KIND_PONG;
                        res_has_byte  = 1'b1;
                        res_byte      = d;
                        res_offset    = r_ping_offset;
                        res_last      = frame_end;
                        n_ping_offset = (r_ping_offset == OFFSET_MAX) ?
                                        r_ping_offset : r_ping_offset + 32'd1;
                    end else if (r_frame_opcode == OP_CLOSE) begin
                        if (frame_end) begin
                            res_valid = 1'b1;
                            res_kind  = KIND_CLOSE;
                        end
                    end else if (r_frame_opcode != OP_PONG) begin
                        res_valid    = 1'b1;
                        res_kind     = KIND_DATA;
                        res_has_byte = 1'b1;
                        res_byte     = d;
                        res_offset   = r_msg_offset;
                        res_last     = frame_end && r_frame_fin;
                        n_msg_offset = (r_msg_offset == OFFSET_MAX) ?
                                       r_msg_offset : r_msg_offset + 32'd1;
                        if (frame_end && r_frame_fin) begin
                            n_msg_open   = 1'b0;
                            n_msg_offset = 32'd0;
                        end
                    end
                end
                default: begin
                    // First header byte; an unknown phase is treated the same.
                    n_frame_fin    = r_in_byte[7];
                    n_frame_opcode = op;
                    n_phase        = PH_HDR1;
                    n_mask_index   = 2'd0;
                    if (op == OP_PING) begin
                        n_ping_offset = 32'd0;
                    end else if (!(op inside {OP_CLOSE, OP_PING, OP_PONG})) begin
                        if (op != OP_CONT) begin
                            // A new data frame abandons any open message.
                            if (r_msg_open) begin
                                res_valid  = 1'b1;
                                res_kind   = KIND_ABANDON;
                                res_offset = r_msg_offset;
                            end
                            n_msg_opcode = op;
                            n_msg_offset = 32'd0;
                        end
                        n_msg_open = r_in_byte[7] ? r_msg_open : 1'b1;
                    end
                end
            endcase

            // Length complete: go on to the mask key, or straight to payload.
            if (do_after_len) begin
                if (n_frame_masked) begin
                    n_phase     = PH_KEY;
                    n_hdr_count = CNT_KEY;
                    n_mask_key  = 32'd0;
                end else begin
                    do_begin = 1'b1;
                end
            end

            // Header complete: a frame with an empty payload ends here.
            if (do_begin) begin
                n_mask_index = 2'd0;
                if (n_remaining != 64'd0) begin
                    n_phase = PH_DATA;
                end else begin
                    n_phase = PH_HDR0;
                    if (r_frame_opcode == OP_PING) begin
                        res_valid = 1'b1;
                        res_kind  = KIND_PONG;
                        res_last  = 1'b1;
                    end else if (r_frame_opcode == OP_CLOSE) begin
                        res_valid = 1'b1;
                        res_kind  = KIND_CLOSE;
                    end else if (r_frame_opcode != OP_PONG && r_frame_fin) begin
                        // End marker only if the message already gave out bytes.
                        if (r_msg_offset != 32'd0) begin
                            res_valid  = 1'b1;
                            res_kind   = KIND_DATA;
                            res_offset = r_msg_offset;
                            res_last   = 1'b1;
                        end
                        n_msg_open   = 1'b0;
                        n_msg_offset = 32'd0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HDR0;
            r_frame_fin    <= 1'b0;
            r_frame_opcode <= OP_CONT;
            r_frame_masked <= 1'b0;
            r_remaining    <= 64'd0;
            r_hdr_count    <= 3'd0;
            r_mask_key     <= 32'd0;
            r_mask_index   <= 2'd0;
            r_msg_opcode   <= OP_TEXT;
            r_msg_open     <= 1'b0;
            r_msg_offset   <= 32'd0;
            r_ping_offset  <= 32'd0;
        end else if (fire) begin
            r_phase        <= n_phase;
            r_frame_fin    <= n_frame_fin;
            r_frame_opcode <= n_frame_opcode;
            r_frame_masked <= n_frame_masked;
            r_remaining    <= n_remaining;
            r_hdr_count    <= n_hdr_count;
            r_mask_key     <= n_mask_key;
            r_mask_index   <= n_mask_index;
            r_msg_opcode   <= n_msg_opcode;
            r_msg_open     <= n_msg_open;
            r_msg_offset   <= n_msg_offset;
            r_ping_offset  <= n_ping_offset;
        end
    end

    // ------------------------------------------------------------------
    // Result register. The message opcode shown is the one held before
    // this transaction, so an abandon report carries the old message's
    // opcode.
    // ------------------------------------------------------------------
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res_valid) begin
            o_kind       <= res_kind;
            o_has_byte   <= res_has_byte;
            o_data_byte  <= res_byte;
            o_msg_opcode <= r_msg_opcode;
            o_offset     <= res_offset;
            o_last       <= res_last;
        end
    end

    assign o_valid = r_out_valid;

endmodule : websocket_frame_deframer

`default_nettype wire
